// ===== rtl/bipa_pkg.sv =====
// Shared types and constants for the bitmap ID pool allocator.
package bipa_pkg;

   localparam int ID_PORT_W = 13;
   localparam int LIMIT_W   = 14;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd8192;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_REL   = 4'b0100,
      ST_SCAN  = 4'b1000
   } state_type;

endpackage

// ===== rtl/bitmap_id_pool_allocator.sv =====
// Bitmap ID pool allocator: a release reads the bitmap word, clears the bit in ST_REL and
// registers the result strobe. Allocate reads one bitmap word per cycle from the map memory,
// from word 0 up to the first hit or to the word holding the last ID below the limit.
// A new request is taken in the cycle the previous result is shown.
// Reset runs a clearing pass (busy high) that zeroes the map and marks ID 0 used; the limit
// register resets to 8192 and is writable any time.
module bitmap_id_pool_allocator #(
   parameter int ID_CAPACITY = 8192,
   parameter int WORD_BITS   = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_op,
   input  logic [bipa_pkg::ID_PORT_W-1:0] req_release_id,
   output logic                           rsp_valid,
   output logic [bipa_pkg::ID_PORT_W-1:0] rsp_granted_id,
   output logic                           rsp_alloc_failed,
   input  logic                           csr_we,
   input  logic [bipa_pkg::LIMIT_W-1:0]   csr_wdata
);

   import bipa_pkg::*;

   localparam int MAP_WORDS = (ID_CAPACITY + WORD_BITS - 1) / WORD_BITS;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int ID_W      = $clog2(ID_CAPACITY);
   localparam int XW        = ((ID_W > LIMIT_W) ? ID_W : LIMIT_W) + 2;

   localparam logic [XW-1:0] CAP_X      = XW'(ID_CAPACITY);
   localparam logic [AW-1:0] LAST_WORDS = AW'(MAP_WORDS - 1);

   state_type             state_ff, state_in;
   logic [LIMIT_W-1:0]    limit_ff;
   logic [AW-1:0]         clr_addr_ff, clr_addr_in;
   logic [AW-1:0]         tag_ff, tag_in;
   logic [AW-1:0]         rel_word_ff, rel_word_in;
   logic [BIT_W-1:0]      rel_bit_ff, rel_bit_in;
   logic                  rel_en_ff, rel_en_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ID_PORT_W-1:0]  rsp_id_ff, rsp_id_in;
   logic                  rsp_fail_ff, rsp_fail_in;

   logic                  accept;
   logic [XW-1:0]         limit_x, eff_x, lim_m1_x, last_word_x;
   logic [XW-1:0]         rid_x, rid_word_x, grant_x;
   logic                  rid_ok;
   logic [AW-1:0]         last_word;
   logic [BIT_W-1:0]      last_bit;

   logic                  wr_en, rd_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [WORD_BITS-1:0]  wr_data, rd_data;
   logic                  found;
   logic [BIT_W-1:0]      bit_idx;
   logic                  at_last;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      limit_x     = XW'(limit_ff);
      eff_x       = ((limit_x == '0) || (limit_x > CAP_X)) ? CAP_X : limit_x;
      lim_m1_x    = eff_x - XW'(1);
      last_word_x = lim_m1_x >> BIT_W;
      rid_x       = XW'(req_release_id);
      rid_word_x  = rid_x >> BIT_W;
      rid_ok      = (rid_x != '0) && (rid_x < CAP_X);
      grant_x     = (XW'(tag_ff) << BIT_W) | XW'(bit_idx);
   end

   assign last_word = last_word_x[AW-1:0];
   assign last_bit  = lim_m1_x[BIT_W-1:0];
   assign at_last   = (tag_ff == last_word);

   bipa_first_free #(
      .WORD_BITS (WORD_BITS),
      .BIT_W     (BIT_W)
   ) u_first_free (
      .word       (rd_data),
      .first_word (tag_ff == '0),
      .last_word  (at_last),
      .last_bit   (last_bit),
      .found      (found),
      .bit_idx    (bit_idx)
   );

   bipa_map_ram #(
      .WORD_BITS (WORD_BITS),
      .DEPTH     (MAP_WORDS),
      .AW        (AW)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      tag_in       = tag_ff;
      rel_word_in  = rel_word_ff;
      rel_bit_in   = rel_bit_ff;
      rel_en_in    = rel_en_ff;
      rsp_valid_in = 1'b0;
      rsp_id_in    = rsp_id_ff;
      rsp_fail_in  = rsp_fail_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = (clr_addr_ff == '0) ? WORD_BITS'(1) : '0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == LAST_WORDS) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               rd_en = 1'b1;
               if (req_op == OP_RELEASE) begin
                  rd_addr     = rid_word_x[AW-1:0];
                  rel_word_in = rid_word_x[AW-1:0];
                  rel_bit_in  = rid_x[BIT_W-1:0];
                  rel_en_in   = rid_ok;
                  state_in    = ST_REL;
               end else begin
                  rd_addr  = '0;
                  tag_in   = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_REL: begin
            wr_en        = rel_en_ff;
            wr_addr      = rel_word_ff;
            wr_data      = rd_data & ~(WORD_BITS'(1) << rel_bit_ff);
            rsp_valid_in = 1'b1;
            rsp_id_in    = '0;
            rsp_fail_in  = 1'b0;
            state_in     = ST_IDLE;
         end
         ST_SCAN: begin
            if (found) begin
               wr_en        = 1'b1;
               wr_addr      = tag_ff;
               wr_data      = rd_data | (WORD_BITS'(1) << bit_idx);
               rsp_valid_in = 1'b1;
               rsp_id_in    = ID_PORT_W'(grant_x);
               rsp_fail_in  = 1'b0;
               state_in     = ST_IDLE;
            end else if (at_last) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = '0;
               rsp_fail_in  = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = tag_ff + AW'(1);
               tag_in  = tag_ff + AW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      tag_ff      <= tag_in;
      rel_word_ff <= rel_word_in;
      rel_bit_ff  <= rel_bit_in;
      rel_en_ff   <= rel_en_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_fail_ff <= rsp_fail_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_id   = rsp_id_ff;
   assign rsp_alloc_failed = rsp_fail_ff;

endmodule

// ===== rtl/bipa_map_ram.sv =====
// Used-ID bitmap memory: one write port, one read port, registered read data.
module bipa_map_ram #(
   parameter int WORD_BITS = 32,
   parameter int DEPTH     = 256,
   parameter int AW        = 8
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WORD_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bipa_first_free.sv =====
// Lowest grantable clear bit of one bitmap word.
module bipa_first_free #(
   parameter int WORD_BITS = 32,
   parameter int BIT_W     = 5
) (
   input  logic [WORD_BITS-1:0] word,
   input  logic                 first_word,
   input  logic                 last_word,
   input  logic [BIT_W-1:0]     last_bit,
   output logic                 found,
   output logic [BIT_W-1:0]     bit_idx
);

   logic [WORD_BITS-1:0] avail;

   always_comb begin
      found   = 1'b0;
      bit_idx = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         avail[b] = !word[b] && (!last_word || (b <= int'(last_bit)))
                    && !(first_word && (b == 0));
      end
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (avail[b]) begin
            found   = 1'b1;
            bit_idx = BIT_W'(b);
         end
      end
   end

endmodule

// ===== rtl/bipa_checker.sv =====
// Port-level checks for the bitmap ID pool allocator, bound to the top level.
module bipa_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           req_op,
   input logic                           rsp_valid,
   input logic [bipa_pkg::ID_PORT_W-1:0] rsp_granted_id,
   input logic                           rsp_alloc_failed
);

   import bipa_pkg::*;

   a_fail_zero_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alloc_failed |-> rsp_granted_id == '0)
      else $error("failed allocation with nonzero ID");

   a_release_rsp: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_op == OP_RELEASE |->
         ##2 (rsp_valid && rsp_granted_id == '0 && !rsp_alloc_failed))
      else $error("release result missing or wrong");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("no busy after transfer");

   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back result strobes");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");

endmodule

bind bitmap_id_pool_allocator bipa_checker u_bipa_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_op           (req_op),
   .rsp_valid        (rsp_valid),
   .rsp_granted_id   (rsp_granted_id),
   .rsp_alloc_failed (rsp_alloc_failed)
);
